// ===== hw/rtl/hashed_window_dedup_table_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the hashed window dedup table
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HASHED_WINDOW_DEDUP_TABLE_MACROS_SVH
`define HASHED_WINDOW_DEDUP_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define HWDT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HWDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HWDT_ASSERT(label, prop, msg)
`define HWDT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/hwdt_pkg.sv =====
// ----------------------------------------------------------------------------
// hwdt_pkg
// Shared constants, controller states and command/status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hwdt_pkg;

  localparam int          SLOT_COUNT_DEF = 128;
  localparam logic [31:0] FNV_BASIS      = 32'h811c9dc5;
  localparam logic [31:0] FNV_PRIME      = 32'h01000193;
  localparam logic [31:0] WINDOW_RESET   = 32'd60000;
  localparam int          KEY_BYTES      = 8;
  localparam int          BYTE_CNT_W     = 3;
  localparam int          SLOT_IDX_W     = 7;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic hash_step;
    logic scan;
    logic write;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic hash_last;
    logic scan_done;
    logic scan_dup;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hashed_window_dedup_table.sv =====
// ----------------------------------------------------------------------------
// hashed_window_dedup_table
// Time-window duplicate filter keyed by a 32-bit FNV-1a hash of each event.
// ----------------------------------------------------------------------------
// After reset the block zeroes every slot of the slot memory and keeps
// in_ready low meanwhile; window_ms writes are taken at any time. Each
// event then passes through the byte-serial hash (one multiply per byte),
// the scan through the single-read-port slot memory (stopped early by a
// fresh match), the slot update when no match was found, and the load of
// the output register, which waits while a held result is not taken. The
// next event is accepted once the block is back in idle. A new event is
// taken while the previous result waits.
`timescale 1ns / 1ps
`default_nettype none

`include "hashed_window_dedup_table_macros.svh"

module hashed_window_dedup_table #(
  parameter int SLOT_COUNT = hwdt_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [31:0]                 cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  detector_id,
  input  wire logic [7:0]                  channel,
  input  wire logic [47:0]                 mac_address,
  input  wire logic [31:0]                 now_ms,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             duplicate,
  output logic [31:0]                      key_hash,
  output logic [hwdt_pkg::SLOT_IDX_W-1:0]  slot_index
);

  hwdt_pkg::cmd_t cmd;
  hwdt_pkg::sts_t sts;
  logic [5:0]     cmd_bits;
  logic           miss_done;

  assign cfg_ready = 1'b1;

  hwdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  hwdt_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .detector_id (detector_id),
    .channel     (channel),
    .mac_address (mac_address),
    .now_ms      (now_ms),
    .duplicate   (duplicate),
    .key_hash    (key_hash),
    .slot_index  (slot_index)
  );

  assign cmd_bits = {cmd.clear, cmd.load, cmd.hash_step, cmd.scan, cmd.write, cmd.publish};
  assign miss_done = sts.scan_done && !sts.scan_dup;

  `HWDT_ASSERT(a_one_cmd, $onehot0(cmd_bits), "more than one datapath command active")
  `HWDT_ASSERT_NEXT(a_hash_follows, in_valid && in_ready, cmd.hash_step, "hash did not start")
  `HWDT_ASSERT(a_write_on_miss, cmd.write |-> $past(miss_done), "slot write without a miss")

endmodule

`default_nettype wire

// ===== hw/rtl/hwdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// hwdt_ctrl
// Sequencer for clearing, hashing, table scan, update and result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hwdt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output hwdt_pkg::cmd_t     cmd,
  input  wire hwdt_pkg::sts_t sts
);

  hwdt_pkg::state_t state;
  hwdt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hwdt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      hwdt_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = hwdt_pkg::ST_IDLE;
        end
      end
      hwdt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = hwdt_pkg::ST_HASH;
        end
      end
      hwdt_pkg::ST_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_last) begin
          state_next = hwdt_pkg::ST_SCAN;
        end
      end
      hwdt_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = sts.scan_dup ? hwdt_pkg::ST_FINISH : hwdt_pkg::ST_WRITE;
        end
      end
      hwdt_pkg::ST_WRITE: begin
        cmd.write  = 1'b1;
        state_next = hwdt_pkg::ST_FINISH;
      end
      hwdt_pkg::ST_FINISH: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = hwdt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hwdt_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hwdt_datapath.sv =====
// ----------------------------------------------------------------------------
// hwdt_datapath
// FNV-1a hash unit, slot memory, scan comparator and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hwdt_datapath #(
  parameter int SLOT_COUNT = hwdt_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire hwdt_pkg::cmd_t                    cmd,
  output hwdt_pkg::sts_t                         sts,
  input  wire logic                              cfg_valid,
  input  wire logic [31:0]                       cfg_data,
  input  wire logic [7:0]                        detector_id,
  input  wire logic [7:0]                        channel,
  input  wire logic [47:0]                       mac_address,
  input  wire logic [31:0]                       now_ms,
  output logic                                   duplicate,
  output logic [31:0]                            key_hash,
  output logic [hwdt_pkg::SLOT_IDX_W-1:0]        slot_index
);

  localparam int             AW   = $clog2(SLOT_COUNT);
  localparam logic [AW-1:0]  LAST = AW'(SLOT_COUNT - 1);
  localparam logic [hwdt_pkg::BYTE_CNT_W-1:0] BYTE_LAST =
    hwdt_pkg::BYTE_CNT_W'(hwdt_pkg::KEY_BYTES - 1);

  logic [31:0]                      window_ms;
  logic [8*hwdt_pkg::KEY_BYTES-1:0] key_sr;
  logic [31:0]                      now_q;
  logic [31:0]                      hash_q;
  logic [hwdt_pkg::BYTE_CNT_W-1:0]  byte_cnt;
  logic [AW-1:0]                    clr_addr;
  logic [AW-1:0]                    rd_addr;
  logic                             rd_done;
  logic                             cmp_vld;
  logic [AW-1:0]                    cmp_idx;
  logic [63:0]                      rd_data;
  logic [31:0]                      best_time;
  logic [AW-1:0]                    best_idx;
  logic                             res_dup;
  logic [AW-1:0]                    res_idx;

  logic [63:0]                      mem [SLOT_COUNT];

  logic [31:0]   hash_mix;
  logic [31:0]   hash_prod;
  logic [31:0]   ent_hash;
  logic [31:0]   ent_time;
  logic [31:0]   age;
  logic          hit;
  logic          take_new;
  logic [AW-1:0] best_idx_next;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic [31:0]   idx_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= hwdt_pkg::WINDOW_RESET;
    end else if (cfg_valid) begin
      window_ms <= cfg_data;
    end
  end

  assign hash_mix  = hash_q ^ 32'(key_sr[8*hwdt_pkg::KEY_BYTES-1 -: 8]);
  assign hash_prod = hash_mix * hwdt_pkg::FNV_PRIME;

  assign ent_hash = rd_data[63:32];
  assign ent_time = rd_data[31:0];
  assign age      = now_q - ent_time;
  assign hit      = (ent_hash == hash_q) && (age < window_ms);

  // Slot 0 seeds the oldest-entry search; later slots replace it only when
  // strictly older, so the first of equal timestamps wins.
  assign take_new      = (cmp_idx == '0) || (ent_time < best_time);
  assign best_idx_next = take_new ? cmp_idx : best_idx;

  assign sts.clear_last = (clr_addr == LAST);
  assign sts.hash_last  = (byte_cnt == BYTE_LAST);
  assign sts.scan_done  = cmp_vld && (hit || (cmp_idx == LAST));
  assign sts.scan_dup   = hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      byte_cnt <= '0;
      rd_addr  <= '0;
      rd_done  <= 1'b0;
      cmp_vld  <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.load) begin
        byte_cnt <= '0;
        rd_addr  <= '0;
        rd_done  <= 1'b0;
        cmp_vld  <= 1'b0;
      end else if (cmd.scan) begin
        cmp_vld <= !rd_done;
        if (!rd_done) begin
          if (rd_addr == LAST) begin
            rd_done <= 1'b1;
          end else begin
            rd_addr <= rd_addr + 1'b1;
          end
        end
      end else begin
        cmp_vld <= 1'b0;
      end
      if (cmd.hash_step) begin
        byte_cnt <= byte_cnt + 1'b1;
      end
    end
  end

  assign mem_we    = cmd.clear || cmd.write;
  assign mem_waddr = cmd.clear ? clr_addr : res_idx;
  assign mem_wdata = cmd.clear ? 64'd0 : {hash_q, now_q};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && !rd_done) begin
      rd_data <= mem[rd_addr];
      cmp_idx <= rd_addr;
    end
  end

  assign idx_ext = 32'(res_idx);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_sr <= {detector_id, channel, mac_address};
      now_q  <= now_ms;
      hash_q <= hwdt_pkg::FNV_BASIS;
    end
    if (cmd.hash_step) begin
      hash_q <= hash_prod;
      key_sr <= {key_sr[8*hwdt_pkg::KEY_BYTES-9:0], 8'h00};
    end
    if (cmd.scan && cmp_vld) begin
      if (take_new) begin
        best_time <= ent_time;
        best_idx  <= cmp_idx;
      end
      if (sts.scan_done) begin
        res_dup <= hit;
        res_idx <= hit ? cmp_idx : best_idx_next;
      end
    end
    if (cmd.publish) begin
      duplicate  <= res_dup;
      key_hash   <= hash_q;
      slot_index <= idx_ext[hwdt_pkg::SLOT_IDX_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for hashed_window_dedup_table
// Drives detection events and window_ms writes through valid/ready channels.
// Every event transfer is run through a behavioral copy of the hash table to
// predict the duplicate flag, key hash and slot index. Each result transfer is
// compared with the oldest prediction. Sender bursts and receiver stalls are
// random.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int SLOTS          = hwdt_pkg::SLOT_COUNT_DEF;
  localparam int IDX_W          = hwdt_pkg::SLOT_IDX_W;
  localparam int POOL_KEYS      = 40;
  localparam int PHASE_COUNT    = 7;
  localparam int PHASE_ITEMS    = 55;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = SLOTS + 16;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum logic [1:0] {
    PLAN_EVENT,
    PLAN_WINDOW,
    PLAN_DRAIN
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t  kind;
    logic [7:0]  eng;
    logic [7:0]  chan;
    logic [47:0] mac;
    logic [31:0] now;
    logic [31:0] window;
  } plan_item_t;

  typedef struct packed {
    logic [7:0]  eng;
    logic [7:0]  chan;
    logic [47:0] mac;
  } key_t;

  typedef struct packed {
    logic             dup;
    logic [31:0]      hash;
    logic [IDX_W-1:0] slot;
  } verdict_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [31:0]      cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       detector_id = '0;
  logic [7:0]       channel = '0;
  logic [47:0]      mac_address = '0;
  logic [31:0]      now_ms = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             duplicate;
  logic [31:0]      key_hash;
  logic [IDX_W-1:0] slot_index;

  // Behavioral copy of the slot table and the window register.
  logic [31:0] slot_hash [SLOTS];
  logic [31:0] slot_time [SLOTS];
  logic [31:0] window_model = hwdt_pkg::WINDOW_RESET;

  plan_item_t event_plan [$];
  verdict_t   expected_verdicts [$];

  int         owed_cnt = 0;
  int         fail_count = 0;
  int         idle_cycles = 0;
  int         hold_cycles = 0;
  int         burst_left = 0;
  bit         draining = 1'b0;
  bit         launch_in;
  bit         launch_cfg;
  plan_item_t next_act;
  int         ready_mode = 0;
  int         ready_left = 0;
  int         delta;
  verdict_t   want;
  verdict_t   got;

  // Top 16 bits of the hash after the first key byte, mapped to that byte.
  logic [8:0] engine_by_top [65536];

  hashed_window_dedup_table #(
    .SLOT_COUNT(SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .detector_id(detector_id),
    .channel(channel),
    .mac_address(mac_address),
    .now_ms(now_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .duplicate(duplicate),
    .key_hash(key_hash),
    .slot_index(slot_index)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] fnv_key(input logic [7:0] eng, input logic [7:0] chan,
                                          input logic [47:0] mac);
    logic [31:0] h;
    logic [63:0] key_bytes;
    key_bytes = {eng, chan, mac};
    h = hwdt_pkg::FNV_BASIS;
    for (int k = 7; k >= 0; k--) begin
      h = (h ^ {24'd0, key_bytes[8*k +: 8]}) * hwdt_pkg::FNV_PRIME;
    end
    return h;
  endfunction

  // Scans the table from slot 0; a fresh match ends the scan, otherwise the
  // first slot holding the smallest timestamp takes the new entry.
  function automatic verdict_t dedup_lookup(input logic [7:0] eng, input logic [7:0] chan,
                                            input logic [47:0] mac, input logic [31:0] now);
    verdict_t    v;
    logic [31:0] oldest;
    logic [31:0] age;
    int          victim;
    v.hash = fnv_key(eng, chan, mac);
    v.dup = 1'b0;
    v.slot = '0;
    victim = 0;
    oldest = slot_time[0];
    for (int i = 0; i < SLOTS; i++) begin
      if (!v.dup) begin
        age = now - slot_time[i];
        if (slot_hash[i] == v.hash && age < window_model) begin
          v.dup = 1'b1;
          v.slot = IDX_W'(i);
        end else if (slot_time[i] < oldest) begin
          oldest = slot_time[i];
          victim = i;
        end
      end
    end
    if (!v.dup) begin
      slot_hash[victim] = v.hash;
      slot_time[victim] = now;
      v.slot = IDX_W'(victim);
    end
    return v;
  endfunction

  task automatic plan_event(input logic [7:0] eng, input logic [7:0] chan,
                            input logic [47:0] mac, input logic [31:0] now);
    plan_item_t p;
    p = '0;
    p.kind = PLAN_EVENT;
    p.eng = eng;
    p.chan = chan;
    p.mac = mac;
    p.now = now;
    event_plan.push_back(p);
  endtask

  task automatic plan_drain();
    plan_item_t p;
    p = '0;
    p.kind = PLAN_DRAIN;
    event_plan.push_back(p);
  endtask

  // The window is only written once every result has come back.
  task automatic plan_window(input logic [31:0] w);
    plan_item_t p;
    plan_drain();
    p = '0;
    p.kind = PLAN_WINDOW;
    p.window = w;
    event_plan.push_back(p);
  endtask

  // Sender: takes planned items in bursts, holds each until its transfer.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
    end else if (!((in_valid && !in_ready) || (cfg_valid && !cfg_ready))) begin
      launch_in = 1'b0;
      launch_cfg = 1'b0;
      if (draining) begin
        if (owed_cnt == 0) begin
          if (hold_cycles != 0) hold_cycles = hold_cycles - 1;
          else draining = 1'b0;
        end
      end else if (hold_cycles != 0) begin
        hold_cycles = hold_cycles - 1;
      end
      if (!draining && hold_cycles == 0 && event_plan.size() != 0) begin
        next_act = event_plan.pop_front();
        case (next_act.kind)
          PLAN_EVENT: begin
            launch_in = 1'b1;
            detector_id <= next_act.eng;
            channel <= next_act.chan;
            mac_address <= next_act.mac;
            now_ms <= next_act.now;
            if (burst_left == 0) burst_left = $urandom_range(1, 8);
            burst_left = burst_left - 1;
            if (burst_left == 0 && $urandom_range(0, 2) != 0) hold_cycles = $urandom_range(1, 300);
          end
          PLAN_WINDOW: begin
            launch_cfg = 1'b1;
            cfg_data <= next_act.window;
          end
          default: begin
            draining = 1'b1;
            hold_cycles = SETTLE_CYCLES;
          end
        endcase
      end
      in_valid <= launch_in;
      cfg_valid <= launch_cfg;
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin
    delta = 0;
    if (rst) begin
      owed_cnt <= 0;
    end else begin
      if (cfg_valid && cfg_ready) window_model = cfg_data;
      if (out_valid && out_ready) begin
        got = {duplicate, key_hash, slot_index};
        if (expected_verdicts.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: duplicate %b key_hash %h slot_index %0d",
                   $time, duplicate, key_hash, slot_index);
        end else begin
          want = expected_verdicts.pop_front();
          delta = delta - 1;
          if (got !== want) begin
            fail_count++;
            $display("%0t: mismatch: duplicate exp %b got %b, key_hash exp %h got %h,",
                     $time, want.dup, got.dup, want.hash, got.hash);
            $display("%0t:   slot_index exp %0d got %0d", $time, want.slot, got.slot);
          end
        end
      end
      // Predict after the check so a result can never match its own event.
      if (in_valid && in_ready) begin
        expected_verdicts.push_back(dedup_lookup(detector_id, channel, mac_address, now_ms));
        delta = delta + 1;
      end
      owed_cnt <= owed_cnt + delta;
    end
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_left = $urandom_range(1, 200);
    end else begin
      ready_left = ready_left - 1;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time, owed_cnt);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [31:0] inv;
    logic [31:0] h;
    logic [31:0] x;
    logic [31:0] y;
    logic [8:0]  z;
    logic [47:0] zmac;
    logic [7:0]  zero_eng;
    logic [7:0]  zero_chan;
    bit          zero_found;
    int          tries;
    key_t        key_pool [POOL_KEYS];
    key_t        key;
    key_t        last_key;
    logic [31:0] phase_window [PHASE_COUNT];
    logic [31:0] w;
    logic [31:0] step_cap;
    logic [31:0] clock_ms;
    int          pick;

    for (int i = 0; i < SLOTS; i++) begin
      slot_hash[i] = '0;
      slot_time[i] = '0;
    end

    // Search for a key that hashes to zero. Running the hash backward from
    // zero over six random MAC bytes leaves a value that must equal the hash
    // after the first byte, up to the channel byte in the low eight bits.
    for (int i = 0; i < 65536; i++) engine_by_top[i] = '0;
    for (int i = 0; i < 256; i++) begin
      y = (hwdt_pkg::FNV_BASIS ^ 32'(i)) * hwdt_pkg::FNV_PRIME;
      engine_by_top[y[31:16]] = {1'b1, 8'(i)};
    end
    inv = hwdt_pkg::FNV_PRIME;
    repeat (5) inv = inv * (32'd2 - hwdt_pkg::FNV_PRIME * inv);
    zero_found = 1'b0;
    zero_eng = '0;
    zero_chan = '0;
    zmac = '0;
    for (tries = 0; tries < 4000000 && !zero_found; tries++) begin
      zmac[47:16] = $urandom();
      zmac[15:0] = 16'($urandom_range(0, 65535));
      h = 32'd0;
      for (int k = 0; k < 6; k++) h = (h * inv) ^ {24'd0, zmac[8*k +: 8]};
      x = h * inv;
      z = engine_by_top[x[31:16]];
      if (z[8]) begin
        y = (hwdt_pkg::FNV_BASIS ^ {24'd0, z[7:0]}) * hwdt_pkg::FNV_PRIME;
        if (x[15:8] == y[15:8]) begin
          zero_eng = z[7:0];
          zero_chan = x[7:0] ^ y[7:0];
          zero_found = 1'b1;
        end
      end
    end

    // A cleared slot holds hash zero at time zero, so this is a duplicate.
    if (zero_found) plan_event(zero_eng, zero_chan, zmac, 32'd5);
    plan_event(8'h00, 8'h00, 48'h0, 32'd100);
    plan_event(8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    plan_event(8'h00, 8'h00, 48'h0, 32'd60099);
    plan_event(8'h00, 8'h00, 48'h0, 32'd60100);
    if (zero_found) plan_event(zero_eng, zero_chan, zmac, 32'd70000);
    // Age taken across the wrap of the millisecond counter.
    plan_event(8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF, 32'h0000_0010);
    plan_event(8'hA5, 8'h5A, 48'hAAAA_5555_AAAA, 32'd1000);
    plan_event(8'h5A, 8'hA5, 48'h5555_AAAA_5555, 32'h8000_0000);
    plan_event(8'hA5, 8'h5A, 48'hAAAA_5555_AAAA, 32'd1001);
    plan_window(32'd0);
    plan_event(8'h12, 8'h34, 48'h0102_0304_0506, 32'd5000);
    plan_event(8'h12, 8'h34, 48'h0102_0304_0506, 32'd5000);
    plan_window(32'd1);
    plan_event(8'h12, 8'h34, 48'h0102_0304_0506, 32'd6000);
    plan_event(8'h12, 8'h34, 48'h0102_0304_0506, 32'd6000);
    plan_event(8'h12, 8'h34, 48'h0102_0304_0506, 32'd6001);
    plan_window(32'hFFFF_FFFF);
    plan_event(8'h12, 8'h34, 48'h0102_0304_0506, 32'd0);
    plan_event(8'h00, 8'h00, 48'h0, 32'hFFFF_FFFE);
    plan_event(8'h5A, 8'hA5, 48'h5555_AAAA_5555, 32'h7FFF_FFFF);

    for (int i = 0; i < POOL_KEYS; i++) begin
      key_pool[i].eng = 8'($urandom_range(0, 255));
      key_pool[i].chan = 8'($urandom_range(0, 255));
      key_pool[i].mac = {16'($urandom_range(0, 65535)), $urandom()};
    end
    phase_window[0] = 32'd60000;
    phase_window[1] = 32'd1;
    phase_window[2] = 32'hFFFF_FFFF;
    phase_window[3] = 32'd0;
    phase_window[4] = $urandom();
    phase_window[5] = 32'd1000;
    phase_window[6] = 32'd60000;
    clock_ms = 32'd200000;
    last_key = key_pool[0];

    // Recurring keys with slowly advancing time, so that repeats land both
    // inside and outside the window; some fresh keys and time jumps as noise.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      w = phase_window[ph];
      plan_window(w);
      if (w <= 32'd4) step_cap = 32'd2;
      else if (w > 32'h0010_0000) step_cap = 32'h0001_0000;
      else step_cap = w / 16;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          key = last_key;
        end else if (pick < 75) begin
          key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
        end else begin
          key.eng = 8'($urandom_range(0, 255));
          key.chan = 8'($urandom_range(0, 255));
          key.mac = {16'($urandom_range(0, 65535)), $urandom()};
        end
        if ($urandom_range(0, 9) == 0) clock_ms = $urandom();
        else clock_ms = clock_ms + $urandom_range(0, step_cap);
        plan_event(key.eng, key.chan, key.mac, clock_ms);
        last_key = key;
        if ($urandom_range(0, 29) == 0) plan_drain();
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (event_plan.size() != 0 || in_valid || cfg_valid || draining || owed_cnt != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_verdicts.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_verdicts.size());
    end
    if (fail_count == 0 && expected_verdicts.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
